[rtl/core/mte_pkg.sv]
package mte_pkg;

    // Sample and gain widths
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_SPACING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_VALUE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE = 3'd4;

    // Gain constants, unsigned Q2.15
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'd32768;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 17'd131071;

    // Offset-binary bias for the 8-bit mode
    localparam logic [7:0] BIAS8 = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // One tap read issued to the tap pipeline
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [GAIN_W-1:0] gain;
    } tap_issue_t;

    // Occupancy of the tap pipeline stages
    typedef struct packed {
        logic s1_busy;
        logic s2_busy;
    } tap_status_t;

endpackage

[rtl/core/mte_ram.sv]
module mte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/mte_gain.sv]
module mte_gain import mte_pkg::*; (
    input  logic              clk,
    input  logic              load,
    input  logic              step,
    input  logic              mode,
    input  logic [15:0]       value,
    output logic [GAIN_W-1:0] gain
);

    localparam int PROD_W = GAIN_W + 16;

    logic [GAIN_W-1:0] gain_reg;
    logic [GAIN_W-1:0] gain_next;
    logic [GAIN_W-1:0] lin_next;
    logic [GAIN_W-1:0] geo_next;
    logic [PROD_W-1:0] geo_prod;
    logic [PROD_W-16:0] geo_shift;

    // Linear: subtract the step, stick at zero once it would go negative
    assign lin_next = (gain_reg >= GAIN_W'(value)) ? (gain_reg - GAIN_W'(value)) : '0;

    // Geometric: multiply by the ratio, truncate, saturate just under 4.0
    assign geo_prod  = PROD_W'(gain_reg) * PROD_W'(value);
    assign geo_shift = geo_prod[PROD_W-1:15];
    assign geo_next  = geo_shift[PROD_W-15-1] ? GAIN_MAX : geo_shift[GAIN_W-1:0];

    always_comb
    begin
        gain_next = gain_reg;
        if (load)
        begin
            gain_next = mode ? GAIN_W'(value) : GAIN_UNITY;
        end
        else if (step)
        begin
            gain_next = mode ? geo_next : lin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_reg <= gain_next;
    end

    assign gain = gain_reg;

endmodule

[rtl/core/mte_tap.sv]
module mte_tap import mte_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic signed [SAMPLE_W-1:0] load_value,
    input  logic                       narrow,
    input  tap_issue_t                 issue,
    input  logic [SAMPLE_W-1:0]        rdata,
    output tap_status_t                status,
    output logic signed [SAMPLE_W-1:0] sum
);

    localparam int MAG_W  = SAMPLE_W + 1;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int ACC_W  = SAMPLE_W + 4;

    localparam logic signed [ACC_W-1:0] HI16 = 20'sd32767;
    localparam logic signed [ACC_W-1:0] LO16 = -20'sd32768;
    localparam logic signed [ACC_W-1:0] HI8  = 20'sd127;
    localparam logic signed [ACC_W-1:0] LO8  = -20'sd128;

    logic                       s1_valid_reg;
    logic                       s1_hit_reg;
    logic [GAIN_W-1:0]          s1_gain_reg;
    logic                       s2_valid_reg;
    logic                       s2_neg_reg;
    logic [GAIN_W-1:0]          s2_mag_reg;
    logic signed [SAMPLE_W-1:0] sum_reg;
    logic signed [SAMPLE_W-1:0] sum_next;

    logic [SAMPLE_W-1:0]        tap_s;
    logic [MAG_W-1:0]           s_ext;
    logic [MAG_W-1:0]           mag;
    logic [PROD_W-1:0]          prod;
    logic [ACC_W-1:0]           mag_ext;
    logic signed [ACC_W-1:0]    term;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    hi;
    logic signed [ACC_W-1:0]    lo;

    // Stage 1: history word back from memory, magnitude times gain
    assign tap_s = s1_hit_reg ? rdata : '0;
    assign s_ext = {tap_s[SAMPLE_W-1], tap_s};
    assign mag   = tap_s[SAMPLE_W-1] ? (~s_ext + 1'b1) : s_ext;
    assign prod  = PROD_W'(mag) * PROD_W'(s1_gain_reg);

    // Stage 2: restore sign, add, saturate to the mode range
    assign mag_ext = ACC_W'(s2_mag_reg);
    assign term    = s2_neg_reg ? $signed(~mag_ext + 1'b1) : $signed(mag_ext);
    assign acc     = $signed({{(ACC_W-SAMPLE_W){sum_reg[SAMPLE_W-1]}}, sum_reg}) + term;
    assign hi      = narrow ? HI8 : HI16;
    assign lo      = narrow ? LO8 : LO16;

    always_comb
    begin
        sum_next = sum_reg;
        if (load)
        begin
            sum_next = load_value;
        end
        else if (s2_valid_reg)
        begin
            priority if (acc > hi)
            begin
                sum_next = hi[SAMPLE_W-1:0];
            end
            else if (acc < lo)
            begin
                sum_next = lo[SAMPLE_W-1:0];
            end
            else
            begin
                sum_next = acc[SAMPLE_W-1:0];
            end
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payload and accumulator
    always_ff @(posedge clk)
    begin
        s1_hit_reg  <= issue.hit;
        s1_gain_reg <= issue.gain;
        s2_neg_reg  <= tap_s[SAMPLE_W-1];
        s2_mag_reg  <= prod[15 +: GAIN_W];
        sum_reg     <= sum_next;
    end

    assign status.s1_busy = s1_valid_reg;
    assign status.s2_busy = s2_valid_reg;
    assign sum            = sum_reg;

    // A product reaches the adder only after a valid stage 1 read
    a_s2_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("tap stage 2 valid without stage 1");

endmodule

[rtl/core/multi_tap_echo_saturating_core.sv]
// Each accepted input issues one history read per tap, the tap count capped at MAX_TAPS,
// on the single read port and through the two-stage tap pipeline; sample_out is registered
// once the taps are summed and can be held back by output stalls. A new input is taken
// only after the previous result has been registered.
// Reset: control, write pointer and configuration registers return to defaults; history memory is
// not cleared, entries not yet written since reset read as silence via the pointer.
module multi_tap_echo_saturating_core import mte_pkg::*; #(
    parameter int MAX_TAPS    = 8,
    parameter int MAX_SPACING = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [SAMPLE_W-1:0]   sample_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SAMPLE_W-1:0]   sample_out
);

    localparam int DEPTH = MAX_TAPS * MAX_SPACING;
    localparam int AW    = $clog2(DEPTH);
    localparam int AWP   = AW + 1;
    localparam int TCW   = $clog2(MAX_TAPS + 1);

    // Configuration registers
    logic [3:0]  tap_count_reg;
    logic [12:0] tap_spacing_reg;
    logic        decay_mode_reg;
    logic [15:0] decay_value_reg;
    logic        sample_mode_reg;

    // Control state
    state_t                     state_reg, state_next;
    logic [TCW-1:0]             taps_reg;
    logic [TCW-1:0]             cnt_reg;
    logic [AWP-1:0]             sp_reg;
    logic [AW-1:0]              base_reg;
    logic [AW-1:0]              write_pos_reg;
    logic                       wrapped_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic signed [SAMPLE_W-1:0] cur_reg;

    logic                       accept;
    logic                       issue_go;
    logic                       done_go;
    logic [7:0]                 byte_s;
    logic signed [SAMPLE_W-1:0] cur_val;
    logic [TCW-1:0]             taps_val;
    logic [AWP-1:0]             sp_val;
    logic [AWP-1:0]             diff;
    logic [AW-1:0]              rd_addr;
    logic [GAIN_W-1:0]          gain;
    tap_issue_t                 issue;
    tap_status_t                tap_status;
    logic signed [SAMPLE_W-1:0] sum;
    logic [SAMPLE_W-1:0]        rdata;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign issue_go  = (state_reg == ST_RUN) && (cnt_reg != taps_reg);
    assign done_go   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Input decode: 8-bit offset binary or 16-bit signed, tail slot is silence
    assign byte_s = sample_in[7:0] ^ BIAS8;
    always_comb
    begin
        if (kind)
        begin
            cur_val = '0;
        end
        else if (!sample_mode_reg)
        begin
            cur_val = {{(SAMPLE_W-8){byte_s[7]}}, byte_s};
        end
        else
        begin
            cur_val = sample_in;
        end
    end

    // Clamp tap count and spacing into their supported ranges
    assign taps_val = (32'(tap_count_reg) > MAX_TAPS) ? TCW'(MAX_TAPS) : TCW'(tap_count_reg);
    always_comb
    begin
        priority if (tap_spacing_reg == '0)
        begin
            sp_val = AWP'(1);
        end
        else if (32'(tap_spacing_reg) > MAX_SPACING)
        begin
            sp_val = AWP'(MAX_SPACING);
        end
        else
        begin
            sp_val = AWP'(tap_spacing_reg);
        end
    end

    // Next tap address: step back one spacing, wrap around the ring
    assign diff    = {1'b0, base_reg} - sp_reg;
    assign rd_addr = diff[AW] ? AW'(diff + AWP'(DEPTH)) : diff[AW-1:0];

    assign issue.valid = issue_go;
    assign issue.hit   = wrapped_reg || (rd_addr < write_pos_reg);
    assign issue.gain  = gain;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if ((cnt_reg == taps_reg) && !tap_status.s1_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg   <= 4'd0;
            tap_spacing_reg <= 13'd1;
            decay_mode_reg  <= 1'b0;
            decay_value_reg <= 16'd32768;
            sample_mode_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TAP_COUNT:   tap_count_reg   <= cfg_data[3:0];
                CFG_TAP_SPACING: tap_spacing_reg <= cfg_data[12:0];
                CFG_DECAY_MODE:  decay_mode_reg  <= cfg_data[0];
                CFG_DECAY_VALUE: decay_value_reg <= cfg_data;
                CFG_SAMPLE_MODE: sample_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            write_pos_reg <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (issue_go)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (done_go)
            begin
                if (write_pos_reg == AW'(DEPTH - 1))
                begin
                    write_pos_reg <= '0;
                    wrapped_reg   <= 1'b1;
                end
                else
                begin
                    write_pos_reg <= write_pos_reg + 1'b1;
                end
            end
            if (done_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Per-transaction payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg  <= cur_val;
            taps_reg <= taps_val;
            sp_reg   <= sp_val;
            base_reg <= write_pos_reg;
        end
        else if (issue_go)
        begin
            base_reg <= rd_addr;
        end
        if (done_go)
        begin
            out_data_reg <= sample_mode_reg ? sum
                                            : {8'h00, sum[7:0] ^ BIAS8};
        end
    end

    mte_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (done_go),
        .waddr (write_pos_reg),
        .wdata (cur_reg),
        .re    (issue_go),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    mte_gain u_gain (
        .clk   (clk),
        .load  (accept),
        .step  (issue_go),
        .mode  (decay_mode_reg),
        .value (decay_value_reg),
        .gain  (gain)
    );

    mte_tap u_tap (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_value (cur_val),
        .narrow     (!sample_mode_reg),
        .issue      (issue),
        .rdata      (rdata),
        .status     (tap_status),
        .sum        (sum)
    );

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

    // New transaction only with the tap pipeline drained
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !tap_status.s1_busy && !tap_status.s2_busy)
        else $error("input taken while taps in flight");

    // Result stage sees all taps issued and summed
    a_done_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (cnt_reg == taps_reg) && !tap_status.s1_busy
                                   && !tap_status.s2_busy)
        else $error("result stage reached with taps outstanding");

    // History write pointer steps by one per stored sample
    a_wpos_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_go && (write_pos_reg != AW'(DEPTH - 1))
        |=> write_pos_reg == $past(write_pos_reg) + AW'(1))
        else $error("write pointer did not advance");

endmodule

[sim/multi_tap_echo_saturating_core_tb.sv]
`timescale 1ns / 100ps

module multi_tap_echo_saturating_core_tb;
    import mte_pkg::*;

    localparam int MAX_TAPS    = 8;
    localparam int MAX_SPACING = 4096;
    localparam int HIST_DEPTH  = MAX_TAPS * MAX_SPACING;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 50;
    localparam int NUM_PHASES  = 12;
    localparam int DRAIN_WAIT  = MAX_TAPS + 8;

    // Echo scoreboard: mirrors the echo datapath and holds the samples still due
    class echo_scoreboard;
        logic signed [SAMPLE_W-1:0] src_hist [HIST_DEPTH];
        int unsigned                wr_ptr;
        logic [GAIN_W-1:0]          gain [MAX_TAPS];
        logic [3:0]                 taps_reg;
        logic [12:0]                spacing_reg;
        logic                       geo_mode;
        logic [15:0]                decay_reg;
        logic                       wide_mode;
        logic [SAMPLE_W-1:0]        due_samples [$];
        int                         outputs_seen;
        int                         errors;

        function new();
            foreach (src_hist[i])
                src_hist[i] = '0;
            wr_ptr       = 0;
            taps_reg     = 4'd0;
            spacing_reg  = 13'd1;
            geo_mode     = 1'b0;
            decay_reg    = 16'd32768;
            wide_mode    = 1'b1;
            outputs_seen = 0;
            errors       = 0;
            update_gains();
        endfunction

        // Q2.15 tap gains, rebuilt after every write to a mapped register
        function void update_gains();
            longint unsigned g;
            longint unsigned dec;
            g = decay_reg;
            for (int d = 0; d < MAX_TAPS; d++)
            begin
                if (!geo_mode)
                begin
                    dec = longint'(d) * decay_reg;
                    gain[d] = (dec >= GAIN_UNITY) ? '0 : GAIN_W'(GAIN_UNITY - dec);
                end
                else
                begin
                    if (d > 0)
                        g = (g * decay_reg) >> 15;
                    if (g > GAIN_MAX)
                        g = GAIN_MAX;
                    gain[d] = g[GAIN_W-1:0];
                end
            end
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TAP_COUNT:   taps_reg    = data[3:0];
                CFG_TAP_SPACING: spacing_reg = data[12:0];
                CFG_DECAY_MODE:  geo_mode    = data[0];
                CFG_DECAY_VALUE: decay_reg   = data;
                CFG_SAMPLE_MODE: wide_mode   = data[0];
                default:         return;   // unmapped index, no effect
            endcase
            update_gains();
        endfunction

        // Accepted input transaction: compute the echoed sample it must produce
        function void take_sample(logic is_tail, logic [SAMPLE_W-1:0] raw);
            int              cur;
            int              lo;
            int              hi;
            int              taps;
            int              sp;
            int              acc;
            int              term;
            int              biased;
            int unsigned     rd;
            longint unsigned mag;
            longint unsigned prod;

            if (!wide_mode)
            begin
                lo  = -128;
                hi  = 127;
                cur = int'(raw[7:0]) - int'(BIAS8);
            end
            else
            begin
                lo  = -32768;
                hi  = 32767;
                cur = int'($signed(raw));
            end
            if (is_tail)
                cur = 0;

            taps = (taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg;
            sp   = (spacing_reg < 1) ? 1 :
                   (spacing_reg > MAX_SPACING) ? MAX_SPACING : spacing_reg;

            // taps in order, saturating after each add
            acc = cur;
            for (int d = 0; d < taps; d++)
            begin
                rd   = (wr_ptr + HIST_DEPTH - (d + 1) * sp) % HIST_DEPTH;
                term = src_hist[rd];
                mag  = (term < 0) ? -term : term;
                prod = (mag * gain[d]) >> 15;
                acc += (term < 0) ? -int'(prod) : int'(prod);
                if (acc > hi)
                    acc = hi;
                if (acc < lo)
                    acc = lo;
            end

            src_hist[wr_ptr] = cur[SAMPLE_W-1:0];
            wr_ptr = (wr_ptr + 1) % HIST_DEPTH;

            if (!wide_mode)
            begin
                biased = acc + int'(BIAS8);
                due_samples.push_back({8'h00, biased[7:0]});
            end
            else
                due_samples.push_back(acc[SAMPLE_W-1:0]);
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_sample_out(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            outputs_seen++;
            if (due_samples.size() == 0)
                report($sformatf("output #%0d sample_out=%h with nothing due",
                                 outputs_seen, got));
            else
            begin
                want = due_samples.pop_front();
                if (got !== want)
                    report($sformatf("output #%0d sample_out=%h, wanted %h",
                                     outputs_seen, got, want));
            end
        endtask

        function int pending();
            return due_samples.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  kind      = 1'b0;
    logic [SAMPLE_W-1:0]   sample_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SAMPLE_W-1:0]   sample_out;

    echo_scoreboard tracker = new();
    bit             holdoff_req = 1'b0;
    int             idle_cycles;

    logic [SAMPLE_W-1:0] corner_vals [8] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000,
                                             16'h007F, 16'h0080, 16'h00FF, 16'hFF00};

    multi_tap_echo_saturating_core #(
        .MAX_TAPS    (MAX_TAPS),
        .MAX_SPACING (MAX_SPACING)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Transaction monitor: register writes, accepted inputs, accepted outputs
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            tracker.apply_reg(cfg_index, cfg_data);
        if (in_valid && in_ready)
            tracker.take_sample(kind, sample_in);
        if (out_valid && out_ready)
            tracker.check_sample_out(sample_out);
    end

    // Watchdog: too long without any transaction ends the run
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL multi_tap_echo_saturating_core");
        $finish;
    end

    // Output side: ready in random segments, plus a long hold-off on request
    initial
    begin
        int seg_len;
        int pattern;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pattern = $urandom_range(0, 3);
                seg_len = $urandom_range(1, 40);
                repeat (seg_len)
                begin
                    case (pattern)
                        0, 1:    out_ready <= 1'b1;
                        2:       out_ready <= ($urandom_range(0, 1) == 1);
                        default: out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_sample(logic is_tail, logic [SAMPLE_W-1:0] value);
        in_valid  <= 1'b1;
        kind      <= is_tail;
        sample_in <= value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Block is idle once nothing is due and the pipeline has had time to empty
    task automatic wait_idle();
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic configure(int taps, int spacing, int dmode, int dval, int smode);
        logic [CFG_IDX_W-1:0] junk_idx;
        wait_idle();
        // a write to an unmapped index must be ignored
        junk_idx = CFG_IDX_W'($urandom_range(int'(CFG_SAMPLE_MODE) + 1,
                                             (1 << CFG_IDX_W) - 1));
        write_reg(junk_idx, 16'($urandom));
        write_reg(CFG_TAP_COUNT, CFG_DATA_W'(taps));
        write_reg(CFG_TAP_SPACING, CFG_DATA_W'(spacing));
        write_reg(CFG_DECAY_MODE, CFG_DATA_W'(dmode));
        write_reg(CFG_DECAY_VALUE, CFG_DATA_W'(dval));
        write_reg(CFG_SAMPLE_MODE, CFG_DATA_W'(smode));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        if ($urandom_range(0, 4) == 0)
            return corner_vals[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    // Bursts of random length with random gaps; some gaps are zero
    task automatic run_stream(int count);
        int   left;
        int   burst;
        int   gap;
        logic is_tail;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                is_tail = ($urandom_range(0, 6) == 0);
                send_sample(is_tail, pick_sample());
            end
            left -= burst;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0 && left > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int taps_w;
        int spacing_w;
        int dmode_w;
        int dval_w;
        int smode_w;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no taps, 16-bit; field extremes and a tail slot
        for (int i = 0; i < 6; i++)
            send_sample(1'b0, corner_vals[i]);
        send_sample(1'b1, 16'hFFFF);
        in_valid <= 1'b0;

        // Tap count above range, spacing zero, geometric ratio at max so gains saturate
        configure(15, 0, 1, 16'hFFFF, 1);
        repeat (4) send_sample(1'b0, 16'h7FFF);
        repeat (4) send_sample(1'b0, 16'h8000);
        send_sample(1'b1, 16'h5A5A);
        in_valid <= 1'b0;

        // 8-bit mode, spacing above range: taps reach unwritten history
        configure(3, 8191, 0, 16'h2000, 0);
        send_sample(1'b0, 16'hFF00);
        send_sample(1'b0, 16'h00FF);
        send_sample(1'b0, 16'h0080);
        send_sample(1'b0, 16'h007F);
        send_sample(1'b1, 16'h1234);
        in_valid <= 1'b0;

        // Still 8-bit mode: 8-bit sum reaching back over history stored in 16-bit mode
        configure(8, 1, 0, 16'h0000, 0);
        send_sample(1'b0, 16'h0080);
        send_sample(1'b0, 16'h0080);
        send_sample(1'b1, 16'h0000);
        in_valid <= 1'b0;

        // Random phases, first two at fixed extremes
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    taps_w = 8; spacing_w = 1; dmode_w = 0; dval_w = 0; smode_w = 1;
                end
                1:
                begin
                    taps_w = 0; spacing_w = 4096; dmode_w = 1; dval_w = 0; smode_w = 0;
                end
                default:
                begin
                    taps_w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15)
                                                         : $urandom_range(0, 8);
                    case ($urandom_range(0, 9))
                        0:       spacing_w = 0;
                        1:       spacing_w = $urandom_range(4097, 8191);
                        2:       spacing_w = $urandom_range(17, 80);
                        default: spacing_w = $urandom_range(1, 16);
                    endcase
                    dmode_w = $urandom_range(0, 1);
                    case ($urandom_range(0, 5))
                        0:       dval_w = 0;
                        1:       dval_w = 65535;
                        2:       dval_w = 32768;
                        default: dval_w = $urandom_range(0, 65535);
                    endcase
                    smode_w = $urandom_range(0, 1);
                end
            endcase
            configure(taps_w, spacing_w, dmode_w, dval_w, smode_w);
            // output side stalls long enough for the input to back up
            if (ph == 3 || ph == 8)
                holdoff_req = 1'b1;
            run_stream(PHASE_ITEMS);
        end

        wait_idle();
        if (tracker.errors == 0)
            $display("PASS multi_tap_echo_saturating_core");
        else
            $display("FAIL multi_tap_echo_saturating_core");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mte_pkg.sv
rtl/core/mte_ram.sv
rtl/core/mte_gain.sv
rtl/core/mte_tap.sv
rtl/core/multi_tap_echo_saturating_core.sv
sim/multi_tap_echo_saturating_core_tb.sv
